>>> src/double_ended_queue_core_assert.svh
// Assertion macros shared by the checker of the deque core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque core check failed");

// Next-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque core check failed");

`endif

>>> src/deq_pkg.sv
package deq_pkg;

  // Default ring size and fixed field widths.
  localparam int DEQ_DEPTH = 16;
  localparam int KIND_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 5;

  // Operation codes; codes 6 and 7 mean nothing and act as a no-op.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_REAR  = 3'd5
  } deq_kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } deq_state_t;

  // Input word.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] entry_byte;
  } deq_in_t;

  // Result word.
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] value_out;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic              is_full;
  } deq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } deq_ctl_t;

endpackage

>>> src/deq_ram.sv
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/deq_ctrl.sv
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output deq_pkg::deq_ctl_t ctl
);
  import deq_pkg::*;

  deq_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands: take a word, execute it, then present the result.
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        ctl.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/deq_dp.sv
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::deq_ctl_t ctl,
  input  deq_pkg::deq_in_t  request,
  output logic              done,
  output deq_pkg::deq_out_t result
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] entry_byte;
  logic [AW-1:0]     front_pos, rear_pos;
  logic [CW-1:0]     held;
  logic              ok, rd_hit;

  logic [AW-1:0]     front_prev, front_succ, rear_prev, rear_succ;
  logic [AW-1:0]     front_pos_next, rear_pos_next, addr;
  logic [CW-1:0]     held_next;
  logic              is_push, is_read, go;
  logic [BYTE_W-1:0] rdata;
  logic [CW+FILL_W-1:0] fill_ext;

  // Latch the accepted word.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind       <= request.kind;
      entry_byte <= request.entry_byte;
    end
  end

  // Ring neighbors of both positions, wrapping at DEPTH.
  always_comb begin
    front_prev = (front_pos == '0) ? AW'(DEPTH - 1) : front_pos - 1'b1;
    front_succ = (front_pos == AW'(DEPTH - 1)) ? '0 : front_pos + 1'b1;
    rear_prev  = (rear_pos == '0) ? AW'(DEPTH - 1) : rear_pos - 1'b1;
    rear_succ  = (rear_pos == AW'(DEPTH - 1)) ? '0 : rear_pos + 1'b1;
  end

  // Decode the operation, choose the slot and the new positions and count.
  always_comb begin
    is_push        = 1'b0;
    is_read        = 1'b0;
    addr           = front_pos;
    front_pos_next = front_pos;
    rear_pos_next  = rear_pos;
    held_next      = held;
    case (kind)
      KIND_PUSH_FRONT: begin
        is_push        = 1'b1;
        addr           = front_prev;
        front_pos_next = front_prev;
        held_next      = held + 1'b1;
      end
      KIND_PUSH_REAR: begin
        is_push       = 1'b1;
        addr          = rear_pos;
        rear_pos_next = rear_succ;
        held_next     = held + 1'b1;
      end
      KIND_POP_FRONT: begin
        is_read        = 1'b1;
        addr           = front_pos;
        front_pos_next = front_succ;
        held_next      = held - 1'b1;
      end
      KIND_POP_REAR: begin
        is_read       = 1'b1;
        addr          = rear_prev;
        rear_pos_next = rear_prev;
        held_next     = held - 1'b1;
      end
      KIND_PEEK_FRONT: begin
        is_read = 1'b1;
        addr    = front_pos;
      end
      KIND_PEEK_REAR: begin
        is_read = 1'b1;
        addr    = rear_prev;
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
    go = (is_push && (held != CW'(DEPTH))) || (is_read && (held != '0));
  end

  // Positions and count change only when the operation succeeds; the ok and read flags are set on every execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_pos <= '0;
      rear_pos  <= '0;
      held      <= '0;
      ok        <= 1'b0;
      rd_hit    <= 1'b0;
    end else if (ctl.exec) begin
      ok     <= go;
      rd_hit <= go && is_read;
      if (go) begin
        front_pos <= front_pos_next;
        rear_pos  <= rear_pos_next;
        held      <= held_next;
      end
    end
  end

  // Slot storage.
  deq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.exec && go && is_push),
    .re    (ctl.exec && go && is_read),
    .addr  (addr),
    .wdata (entry_byte),
    .rdata (rdata)
  );

  // Result word; the count is cut or widened to the fill field.
  assign fill_ext          = {{FILL_W{1'b0}}, held};
  assign done              = ctl.emit;
  assign result.ok         = ok;
  assign result.value_out  = rd_hit ? rdata : '0;
  assign result.fill_count = fill_ext[FILL_W-1:0];
  assign result.is_empty   = (held == '0);
  assign result.is_full    = (held == CW'(DEPTH));

endmodule

>>> src/double_ended_queue_core.sv
// Double-ended byte queue over a ring of DEPTH slots in a single-port RAM.
// Raise start with a word on request while busy is low; the word is taken
// at that edge and busy stays high through the execute and result states.
// The execute state applies the operation to the RAM port, and in the following
// cycle done is high for exactly one cycle with the result word on result, so
// no new word is taken until that result is out. The result cannot be held
// off: the receiver must capture it in the cycle that done is high. A pop
// or peek on an empty queue, a push on a full one and an unused operation
// code all return ok low, value_out zero and leave the queue unchanged.
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  request,
  output logic              done,
  output deq_pkg::deq_out_t result
);
  import deq_pkg::*;

  deq_ctl_t ctl;

  // Sequencing.
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Positions, count and slot storage.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

>>> src/deq_checker.sv
`include "double_ended_queue_core_assert.svh"

module deq_core_props (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input deq_pkg::deq_out_t result
);
  import deq_pkg::*;

  // A result only appears while the core is occupied.
  `DEQ_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  // A taken word keeps the core busy with no result in the next cycle.
  `DEQ_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy && !done)
  // Every taken word yields its result once the execute state has passed.
  `DEQ_ASSERT_NOW(a_take_done, clk, rst, start && !busy, ##2 done)
  // A failed operation never returns data.
  `DEQ_ASSERT_NOW(a_fail_zero, clk, rst, done && !result.ok, result.value_out == '0)

endmodule

bind double_ended_queue_core deq_core_props u_deq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

>>> tb/sv/deq_checker.sv
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  deq_pkg::deq_in_t  request,
  input  logic              done,
  input  deq_pkg::deq_out_t result,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Shadow copy of the ring and its positions.
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       entry_cnt;

  // Result words predicted for accepted words, oldest first.
  deq_out_t expected_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Applies one operation to the shadow deque and returns the result word it yields.
  function automatic deq_out_t apply_deque_op(deq_in_t w);
    deq_out_t r;
    r = '0;
    case (w.kind)
      KIND_PUSH_FRONT: begin
        if (entry_cnt < DEPTH) begin
          head_idx = ring_prev(head_idx);
          ring_mem[head_idx] = w.entry_byte;
          entry_cnt++;
          r.ok = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (entry_cnt < DEPTH) begin
          ring_mem[tail_idx] = w.entry_byte;
          tail_idx = ring_next(tail_idx);
          entry_cnt++;
          r.ok = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (entry_cnt != 0) begin
          r.value_out = ring_mem[head_idx];
          head_idx = ring_next(head_idx);
          entry_cnt--;
          r.ok = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (entry_cnt != 0) begin
          tail_idx = ring_prev(tail_idx);
          r.value_out = ring_mem[tail_idx];
          entry_cnt--;
          r.ok = 1'b1;
        end
      end
      KIND_PEEK_FRONT: begin
        if (entry_cnt != 0) begin
          r.value_out = ring_mem[head_idx];
          r.ok = 1'b1;
        end
      end
      KIND_PEEK_REAR: begin
        if (entry_cnt != 0) begin
          r.value_out = ring_mem[ring_prev(tail_idx)];
          r.ok = 1'b1;
        end
      end
      default: begin
        // Unused operation codes change nothing.
      end
    endcase
    r.fill_count = FILL_W'(entry_cnt);
    r.is_empty   = (entry_cnt == 0);
    r.is_full    = (entry_cnt == DEPTH);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] deque result error, %s: expected %0h, got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // Match each result word against the oldest prediction, then predict for a new word.
  always @(posedge clk) begin
    deq_out_t want;
    if (rst) begin
      head_idx  = 0;
      tail_idx  = 0;
      entry_cnt = 0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing pending", 32'd0, 32'(result));
        end else begin
          want = expected_words.pop_front();
          if (result.ok !== want.ok)
            report_mismatch("ok", 32'(want.ok), 32'(result.ok));
          if (result.value_out !== want.value_out)
            report_mismatch("value_out", 32'(want.value_out), 32'(result.value_out));
          if (result.fill_count !== want.fill_count)
            report_mismatch("fill_count", 32'(want.fill_count), 32'(result.fill_count));
          if (result.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(want.is_empty), 32'(result.is_empty));
          if (result.is_full !== want.is_full)
            report_mismatch("is_full", 32'(want.is_full), 32'(result.is_full));
        end
      end
      if (start && !busy) begin
        expected_words.push_back(apply_deque_op(request));
      end
    end
    pending = expected_words.size();
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Operation codes the block treats as a no-op.
  localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;

  localparam int RANDOM_WORDS = 1450;
  localparam int STALL_LIMIT  = 500;
  localparam int TAIL_CYCLES  = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  deq_in_t  request = '0;
  logic     busy;
  logic     done;
  deq_out_t result;
  int       fail_count;
  int       pending;
  int       stall_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue_core u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  deq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: too many cycles with no word taken and no result means a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("double_ended_queue_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic deq_in_t make_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
    deq_in_t w;
    w.kind       = kind;
    w.entry_byte = data;
    return w;
  endfunction

  // Random operation; push_pct sets the percentage of pushes.
  function automatic deq_in_t pick_word(int push_pct);
    int roll;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(99);
    if (roll < 3)
      kind = $urandom_range(1) ? KIND_NOP_HI : KIND_NOP_LO;
    else if (roll < 3 + push_pct)
      kind = $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
    else if ($urandom_range(9) < 7)
      kind = $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
    else
      kind = $urandom_range(1) ? KIND_PEEK_REAR : KIND_PEEK_FRONT;
    return make_word(kind, BYTE_W'($urandom));
  endfunction

  // Gap before a word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one word after an idle gap and hold it until the block takes it.
  task automatic send_word(deq_in_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
  endtask

  // Stop offering words until every pending result word has come back.
  // The count is looked at on the falling edge, after the checker has
  // booked the word taken at the last rising edge.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int push_pct;
    int burst_left;
    bit quiet;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty deque: every pop and peek fails; unused codes do nothing.
    send_word(make_word(KIND_POP_FRONT, 8'hFF), 0);
    send_word(make_word(KIND_POP_REAR, 8'hFF), 0);
    send_word(make_word(KIND_PEEK_FRONT, 8'h00), 0);
    send_word(make_word(KIND_PEEK_REAR, 8'hFF), 0);
    send_word(make_word(KIND_NOP_LO, 8'hA5), 0);
    send_word(make_word(KIND_NOP_HI, 8'hFF), 0);

    // Fill from both ends, which wraps the front position below zero.
    for (int i = 0; i < DEQ_DEPTH; i++) begin
      send_word(make_word(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT,
                          (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : BYTE_W'($urandom)), 0);
    end

    // Full deque: pushes fail, peeks see both ends.
    send_word(make_word(KIND_PUSH_FRONT, 8'h5A), 0);
    send_word(make_word(KIND_PUSH_REAR, 8'hFF), 0);
    send_word(make_word(KIND_PEEK_FRONT, 8'h00), 0);
    send_word(make_word(KIND_PEEK_REAR, 8'h00), 0);
    drain();

    // Random bursts alternate between filling, holding level and draining.
    push_pct   = 45;
    burst_left = 0;
    quiet      = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        case ($urandom_range(2))
          0: push_pct = 20;
          1: push_pct = 45;
          default: push_pct = 85;
        endcase
        burst_left = $urandom_range(60, 20);
        quiet      = ($urandom_range(9) < 3);
      end
      burst_left--;
      send_word(pick_word(push_pct), quiet ? 0 : pick_gap());
      if (n % 250 == 249) drain();
    end

    // Let the last result words arrive and idle for stragglers before reporting.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("double_ended_queue_core: match");
    else
      $display("double_ended_queue_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue_core.sv
src/deq_checker.sv
tb/sv/deq_checker.sv
tb/sv/tb_top.sv
